>>> src/msbbp_pkg.sv
package msbbp_pkg;

  localparam int unsigned ValueW = 64;
  localparam int unsigned WidthW = 7;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned HeldW  = 7;
  localparam int unsigned CntW   = 3;
  // held bits plus one full field, left aligned
  localparam int unsigned WordW  = ValueW + ByteW;

  typedef struct packed {
    logic [ValueW-1:0] bits;   // field bits, left aligned, unused low bits zero
    logic [WidthW-1:0] width;  // clamped width
    logic              eop;
  } entry_t;

endpackage

>>> src/msbbp_front.sv
module msbbp_front #(
  parameter int unsigned MAX_FIELD_BITS = 64
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [msbbp_pkg::ValueW-1:0]     field_value_i,
  input  logic [msbbp_pkg::WidthW-1:0]     field_width_i,
  input  logic                             end_of_packet_i,
  output logic                             q_valid_o,
  input  logic                             q_pop_i,
  output msbbp_pkg::entry_t                q_entry_o
);

  localparam logic [msbbp_pkg::WidthW-1:0] MaxW = msbbp_pkg::WidthW'(MAX_FIELD_BITS);
  localparam logic [msbbp_pkg::WidthW-1:0] FullW = msbbp_pkg::WidthW'(msbbp_pkg::ValueW);

  msbbp_pkg::entry_t        entry;
  msbbp_pkg::entry_t        mem_q [2];
  logic                     wr_ptr_q, wr_ptr_d;
  logic                     rd_ptr_q, rd_ptr_d;
  logic [1:0]               count_q, count_d;
  logic [msbbp_pkg::WidthW-1:0] width;
  logic                     push;

  // clamp the width and left align the field; the shift drops bits above it
  always_comb begin
    width = (field_width_i > MaxW) ? MaxW : field_width_i;
    entry.bits  = field_value_i << (FullW - width);
    entry.width = width;
    entry.eop   = end_of_packet_i;
  end

  assign in_stall_o = (count_q == 2'd2);
  assign push       = in_valid_i && !in_stall_o;
  assign q_valid_o  = (count_q != 2'd0);
  assign q_entry_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ push;
    rd_ptr_d = rd_ptr_q ^ q_pop_i;
    count_d  = count_q + {1'b0, push} - {1'b0, q_pop_i};
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= entry;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

>>> src/msbbp_back.sv
module msbbp_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          q_valid_i,
  output logic                          q_pop_o,
  input  msbbp_pkg::entry_t             q_entry_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [msbbp_pkg::ByteW-1:0]   packed_byte_o,
  output logic                          last_of_run_o,
  output logic                          packet_end_o
);

  localparam logic [msbbp_pkg::WidthW-1:0] ByteBits = msbbp_pkg::WidthW'(msbbp_pkg::ByteW);

  // held bits are kept left aligned, low unused bits zero
  logic [msbbp_pkg::HeldW-1:0]  held_q, held_d;
  logic [msbbp_pkg::CntW-1:0]   cnt_q, cnt_d;
  logic                         busy_q, busy_d;
  logic [msbbp_pkg::WordW-1:0]  rem_q, rem_d;
  logic [msbbp_pkg::WidthW-1:0] tot_q, tot_d;
  logic                         eop_q, eop_d;
  logic                         out_valid_q, out_valid_d;
  logic [msbbp_pkg::ByteW-1:0]  byte_q, byte_d;
  logic                         last_q, last_d;
  logic                         pend_q, pend_d;

  logic                         emit_ok, fire, done, has_full, last;
  logic [msbbp_pkg::WidthW-1:0] tot_after, tot_l;
  logic [msbbp_pkg::WordW-1:0]  rem_after, word;
  logic [msbbp_pkg::HeldW-1:0]  cur_held;
  logic [msbbp_pkg::CntW-1:0]   cur_cnt;

  always_comb begin
    emit_ok   = !out_valid_q || !out_stall_i;
    has_full  = (tot_q >= ByteBits);
    tot_after = has_full ? (tot_q - ByteBits) : '0;
    rem_after = rem_q << msbbp_pkg::ByteW;
    last      = !((tot_after >= ByteBits) || (eop_q && (tot_after != '0)));
    fire      = busy_q && emit_ok;
    done      = fire && last;
    q_pop_o   = q_valid_i && (!busy_q || done);

    // state left behind by the item finishing this cycle
    if (done) begin
      cur_held = eop_q ? '0 : rem_after[msbbp_pkg::WordW-1 -: msbbp_pkg::HeldW];
      cur_cnt  = eop_q ? '0 : tot_after[msbbp_pkg::CntW-1:0];
    end else begin
      cur_held = held_q;
      cur_cnt  = cnt_q;
    end

    word  = {cur_held, {(msbbp_pkg::WordW-msbbp_pkg::HeldW){1'b0}}}
          | ({q_entry_i.bits, {msbbp_pkg::ByteW{1'b0}}} >> cur_cnt);
    tot_l = {{(msbbp_pkg::WidthW-msbbp_pkg::CntW){1'b0}}, cur_cnt} + q_entry_i.width;

    held_d = cur_held;
    cnt_d  = cur_cnt;
    busy_d = busy_q;
    rem_d  = rem_q;
    tot_d  = tot_q;
    eop_d  = eop_q;

    priority if (q_pop_o) begin
      if ((tot_l < ByteBits) && !(q_entry_i.eop && (tot_l != '0))) begin
        // request makes no byte: fold it into the held bits
        held_d = q_entry_i.eop ? '0 : word[msbbp_pkg::WordW-1 -: msbbp_pkg::HeldW];
        cnt_d  = q_entry_i.eop ? '0 : tot_l[msbbp_pkg::CntW-1:0];
        busy_d = 1'b0;
      end else begin
        busy_d = 1'b1;
        rem_d  = word;
        tot_d  = tot_l;
        eop_d  = q_entry_i.eop;
      end
    end else if (done) begin
      busy_d = 1'b0;
    end else if (fire) begin
      rem_d = rem_after;
      tot_d = tot_after;
    end else begin
      busy_d = busy_q;
    end

    out_valid_d = out_valid_q;
    byte_d      = byte_q;
    last_d      = last_q;
    pend_d      = pend_q;
    if (fire) begin
      out_valid_d = 1'b1;
      byte_d      = rem_q[msbbp_pkg::WordW-1 -: msbbp_pkg::ByteW];
      last_d      = last;
      pend_d      = last && eop_q;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    tot_q  <= tot_d;
    eop_q  <= eop_d;
    byte_q <= byte_d;
    last_q <= last_d;
    pend_q <= pend_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q      <= '0;
      cnt_q       <= '0;
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      held_q      <= held_d;
      cnt_q       <= cnt_d;
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign packed_byte_o = byte_q;
  assign last_of_run_o = last_q;
  assign packet_end_o  = pend_q;

endmodule

>>> src/msb_first_bit_packer_core.sv
// Throughput: one output byte per cycle while out_stall_i is low; the back end pops the next
// request in the same cycle as the last byte of the current one. Set by the single output byte register.
// A 2-entry queue sits between the input stage and the byte engine.
// Reset (rst_ni low, asynchronous) empties the queue, clears held bits and drops output valid.
module msb_first_bit_packer_core #(
  parameter int unsigned MAX_FIELD_BITS = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [msbbp_pkg::ValueW-1:0]  field_value_i,
  input  logic [msbbp_pkg::WidthW-1:0]  field_width_i,
  input  logic                          end_of_packet_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [msbbp_pkg::ByteW-1:0]   packed_byte_o,
  output logic                          last_of_run_o,
  output logic                          packet_end_o
);

  logic              q_valid;
  logic              q_pop;
  msbbp_pkg::entry_t q_entry;

  msbbp_front #(
    .MAX_FIELD_BITS(MAX_FIELD_BITS)
  ) u_front (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .field_value_i,
    .field_width_i,
    .end_of_packet_i,
    .q_valid_o (q_valid),
    .q_pop_i   (q_pop),
    .q_entry_o (q_entry)
  );

  msbbp_back u_back (
    .clk_i,
    .rst_ni,
    .q_valid_i (q_valid),
    .q_pop_o   (q_pop),
    .q_entry_i (q_entry),
    .out_valid_o,
    .out_stall_i,
    .packed_byte_o,
    .last_of_run_o,
    .packet_end_o
  );

endmodule

>>> src/msbbp_checker.sv
module msbbp_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         out_valid_o,
  input logic                         out_stall_i,
  input logic [msbbp_pkg::ByteW-1:0]  packed_byte_o,
  input logic                         last_of_run_o,
  input logic                         packet_end_o
);

  // the final byte of a packet always closes its request's run
  a_end_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && packet_end_o |-> last_of_run_o)
    else $error("packet_end without last_of_run");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(packed_byte_o)
      && $stable(last_of_run_o) && $stable(packet_end_o))
    else $error("stalled output request changed");

  // nothing can reach the output register in the first cycle out of reset
  a_quiet_after_reset: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o)
    else $error("output valid right after reset");

endmodule

bind msb_first_bit_packer_core msbbp_checker u_msbbp_checker (
  .clk_i,
  .rst_ni,
  .out_valid_o,
  .out_stall_i,
  .packed_byte_o,
  .last_of_run_o,
  .packet_end_o
);

>>> tb/sv/tb.sv
`timescale 1ns / 100ps

module tb;

  localparam int unsigned ValueW       = msbbp_pkg::ValueW;
  localparam int unsigned WidthW       = msbbp_pkg::WidthW;
  localparam int unsigned ByteW        = msbbp_pkg::ByteW;
  localparam int unsigned HeldW        = msbbp_pkg::HeldW;
  localparam int unsigned CntW         = msbbp_pkg::CntW;
  localparam int unsigned MaxFieldBits = 64;
  localparam int unsigned IdleLimit    = 3000;
  localparam int unsigned HoldOffLen   = 400;
  localparam int unsigned RandomFields = 370;

  typedef struct packed {
    logic [ValueW-1:0] value;
    logic [WidthW-1:0] width;
    logic              eop;
    logic              drain;  // sender waits for every byte before offering this one
  } field_req_t;

  typedef struct packed {
    logic [ByteW-1:0] data;
    logic             run_last;
    logic             pkt_end;
  } packed_byte_t;

  logic              clk = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [ValueW-1:0] field_value = '0;
  logic [WidthW-1:0] field_width = '0;
  logic              end_of_packet = 1'b0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [ByteW-1:0]  packed_byte;
  logic              last_of_run;
  logic              packet_end;

  field_req_t   pending_fields[$];
  packed_byte_t expected_bytes[$];

  // packer state mirror
  logic [HeldW-1:0] held_bits = '0;
  logic [CntW-1:0]  held_count = '0;

  bit          in_fire = 1'b0;
  int unsigned fields_taken = 0;
  int unsigned errors = 0;
  int unsigned idle_cycles = 0;

  msb_first_bit_packer_core #(
    .MAX_FIELD_BITS(MaxFieldBits)
  ) uut (
    .clk_i          (clk),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .field_value_i  (field_value),
    .field_width_i  (field_width),
    .end_of_packet_i(end_of_packet),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .packed_byte_o  (packed_byte),
    .last_of_run_o  (last_of_run),
    .packet_end_o   (packet_end)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Appends one field to the mirrored stream and queues the bytes it completes.
  function automatic void pack_field(logic [ValueW-1:0] value, logic [WidthW-1:0] width,
                                     logic eop);
    logic [ByteW-1:0] acc;
    logic [ByteW-1:0] made[9];
    packed_byte_t     byte_ent;
    int               cnt;
    int               nbits;
    int               n;
    acc   = {1'b0, held_bits};
    cnt   = int'(held_count);
    nbits = (width > MaxFieldBits) ? MaxFieldBits : width;
    n     = 0;
    for (int i = nbits; i > 0; i--) begin
      acc = {acc[ByteW-2:0], value[i-1]};
      cnt++;
      if (cnt == ByteW) begin
        made[n] = acc;
        n++;
        acc = '0;
        cnt = 0;
      end
    end
    if (eop) begin
      if (cnt != 0) begin
        made[n] = acc << (ByteW - cnt);
        n++;
      end
      acc = '0;
      cnt = 0;
    end
    for (int k = 0; k < n; k++) begin
      byte_ent = '{data: made[k], run_last: (k == n - 1), pkt_end: (k == n - 1) && eop};
      expected_bytes = {expected_bytes, byte_ent};
    end
    held_bits  = acc[HeldW-1:0];
    held_count = cnt[CntW-1:0];
  endfunction

  task automatic add_field(logic [ValueW-1:0] value, int unsigned width, logic eop,
                           logic drain = 1'b0);
    field_req_t req;
    req = '{value: value, width: width[WidthW-1:0], eop: eop, drain: drain};
    pending_fields = {pending_fields, req};
  endtask

  function automatic logic [ValueW-1:0] rand_value();
    return {$urandom, $urandom};
  endfunction

  // Sampling side: predicts on accepted requests, checks accepted bytes.
  always @(posedge clk) begin
    packed_byte_t want;
    in_fire = rst_ni && in_valid && !in_stall;
    if (in_fire) begin
      pack_field(field_value, field_width, end_of_packet);
      fields_taken++;
    end
    if (rst_ni && out_valid && !out_stall) begin
      if (expected_bytes.size() == 0) begin
        $display("%0t: unexpected byte, expected none, got %h last=%b end=%b",
                 $time, packed_byte, last_of_run, packet_end);
        errors++;
      end else begin
        want = expected_bytes.pop_front();
        if (want.data !== packed_byte || want.run_last !== last_of_run ||
            want.pkt_end !== packet_end) begin
          $display("%0t: byte mismatch, expected %h last=%b end=%b, got %h last=%b end=%b",
                   $time, want.data, want.run_last, want.pkt_end,
                   packed_byte, last_of_run, packet_end);
          errors++;
        end
      end
    end
  end

  // Sender: bursts of random length separated by random gaps.
  int unsigned burst_left = 4;
  int unsigned gap_left = 0;

  always @(negedge clk) begin
    field_req_t  req;
    logic        v_next;
    v_next = in_valid;
    if (rst_ni && !(in_valid && !in_fire)) begin
      v_next = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (pending_fields.size() > 0 &&
                   !(pending_fields[0].drain && expected_bytes.size() != 0)) begin
        req = pending_fields.pop_front();
        field_value   <= req.value;
        field_width   <= req.width;
        end_of_packet <= req.eop;
        v_next = 1'b1;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 30);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
        end
      end
    end
    in_valid <= v_next;
  end

  // Receiver: changing stall pattern, plus one long hold-off to back the block up.
  int unsigned stall_mode = 0;
  int unsigned mode_left = 50;
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;

  always @(negedge clk) begin
    logic s_next;
    s_next = 1'b0;
    if (!hold_done && fields_taken >= 120) begin
      hold_done = 1'b1;
      hold_left = HoldOffLen;
    end
    if (hold_left > 0) begin
      hold_left--;
      s_next = 1'b1;
    end else begin
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left  = $urandom_range(20, 120);
      end else begin
        mode_left--;
      end
      case (stall_mode)
        0: s_next = 1'b0;
        1: s_next = ($urandom_range(0, 3) == 0);
        2: s_next = ($urandom_range(0, 3) != 0);
        default: s_next = (mode_left[1:0] == 2'b00);
      endcase
    end
    out_stall <= s_next;
  end

  always @(posedge clk) begin
    if (rst_ni) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IdleLimit) begin
        $display("FAIL msb_first_bit_packer_core");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    int unsigned r;
    int unsigned w;
    rst_ni = 1'b0;

    // directed: zero width, empty flush, extremes, clamp, exact fill, nine-byte item
    add_field(64'hFFFF_FFFF_FFFF_FFFF, 0, 1'b0);
    add_field(64'h0, 0, 1'b1);
    add_field(64'hFFFF_FFFF_FFFF_FFFF, 64, 1'b0);
    add_field(64'h0, 64, 1'b1);
    add_field(64'hFFFF_FFFF_FFFF_FFFE, 1, 1'b0);
    add_field(64'hFFFF_FFFF_FFFF_FF81, 7, 1'b1);
    add_field(64'hA5, 8, 1'b1);
    add_field(64'h5, 3, 1'b0);
    add_field(64'h1A, 5, 1'b1);
    add_field(64'h1, 1, 1'b0);
    add_field(64'h0, 0, 1'b1);
    add_field(64'h7F, 7, 1'b0);
    add_field(64'h8000_0000_0000_0001, 64, 1'b1);
    add_field(64'h6D, 7, 1'b0);
    add_field(64'hDEAD_BEEF_0123_4567, 127, 1'b0);
    add_field(64'h0123_4567_89AB_CDEF, 65, 1'b0);
    add_field(64'hFEDC_BA98_7654_3210, 100, 1'b1);
    add_field(64'h3, 2, 1'b0);
    add_field(64'hFFFF_FFFF_FFFF_FFFF, 127, 1'b1);
    add_field(64'h5555_5555_5555_5555, 64, 1'b0);
    add_field(64'hAAAA_AAAA_AAAA_AAAA, 6, 1'b0);
    add_field(64'h0, 0, 1'b0);
    add_field(64'h3, 2, 1'b1);

    for (int i = 0; i < RandomFields; i++) begin
      r = $urandom_range(0, 99);
      if (r < 5)       w = 0;
      else if (r < 15) w = $urandom_range(65, 127);
      else if (r < 30) w = $urandom_range(57, 64);
      else             w = $urandom_range(1, 16);
      add_field(rand_value(), w, ($urandom_range(0, 5) == 0), (i == 250));
    end

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_ni = 1'b1;

    while (pending_fields.size() != 0 || in_valid) @(posedge clk);
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);

    if (errors == 0 && expected_bytes.size() == 0) begin
      $display("PASS msb_first_bit_packer_core");
    end else begin
      $display("FAIL msb_first_bit_packer_core");
    end
    $finish;
  end

endmodule

>>> files.f
src/msbbp_pkg.sv
src/msbbp_front.sv
src/msbbp_back.sv
src/msb_first_bit_packer_core.sv
src/msbbp_checker.sv
tb/sv/tb.sv
